// File: src/poct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package poct_pkg;

	localparam int BUCKETS   = 10;
	localparam int NUM_W     = 10;
	localparam int LET_W     = 24;
	localparam int BKT_W     = 4;
	localparam int HIT_CNT_W = 16;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;

	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_C = 8'h63;
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_G = 8'h67;
	localparam logic [7:0] CH_I = 8'h69;
	localparam logic [7:0] CH_J = 8'h6a;
	localparam logic [7:0] CH_L = 8'h6c;
	localparam logic [7:0] CH_M = 8'h6d;
	localparam logic [7:0] CH_O = 8'h6f;
	localparam logic [7:0] CH_P = 8'h70;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_S = 8'h73;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_V = 8'h76;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_Y = 8'h79;
	localparam logic [7:0] CH_Z = 8'h7a;

	typedef struct packed {
		logic load;
		logic search;
		logic commit;
	} poct_cmd_t;

	typedef struct packed {
		logic issue_more;
		logic cmp_vld;
		logic match;
		logic out_free;
	} poct_status_t;

	function automatic logic [BKT_W-1:0] bucket_of(input logic [7:0] ch);
		logic [BKT_W-1:0] b;
		b = BKT_W'(0);
		if (ch >= CH_A && ch <= CH_C) b = BKT_W'(1);
		else if (ch >= CH_D && ch <= CH_F) b = BKT_W'(2);
		else if (ch >= CH_G && ch <= CH_I) b = BKT_W'(3);
		else if (ch >= CH_J && ch <= CH_L) b = BKT_W'(4);
		else if (ch >= CH_M && ch <= CH_O) b = BKT_W'(5);
		else if (ch >= CH_P && ch <= CH_R) b = BKT_W'(6);
		else if (ch >= CH_S && ch <= CH_U) b = BKT_W'(7);
		else if (ch >= CH_V && ch <= CH_X) b = BKT_W'(8);
		else if (ch >= CH_Y && ch <= CH_Z) b = BKT_W'(9);
		return b;
	endfunction

endpackage

`default_nettype wire

// File: src/plate_occurrence_counting_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Plate occurrence counter: each plate key (number and three letters) lands in one of ten
// buckets chosen by its middle letter, and the bucket's filled ways are walked through the
// entry RAM, one read per cycle. A hit bumps the stored count (saturating at
// 2^COUNT_BITS-1); a miss claims the next free way with count 1, or reports table_full when
// the bucket has none. Exactly one result beat leaves per input beat, in order. For each
// accepted key the RAM read port steps through the filled ways of its bucket, each read
// registered before its compare, and the search ends at the first match or after the last
// filled way; the update cycle then holds while the previous result has not been taken. The
// next key is taken while a result still waits at the output register. Per-bucket fill
// counts, cleared at reset, mark which ways hold data, so no clearing pass runs after reset.
module plate_occurrence_counting_table
	import poct_pkg::*;
#(
	parameter int WAYS       = 8,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // plate_number[9:0], plate_letters[33:10]
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,  // hit_count[15:0], bucket_index[19:16]
	output logic      [OUT_USER_W-1:0] m_axis_tuser   // first_time[0], table_full[1]
);

	poct_cmd_t            cmd;
	poct_status_t         status;
	logic [HIT_CNT_W-1:0] hit_count;
	logic                 first_time;
	logic                 table_full;
	logic [BKT_W-1:0]     bucket_index;

	poct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	poct_dp #(
		.WAYS       (WAYS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.plate_number  (s_axis_tdata[NUM_W-1:0]),
		.plate_letters (s_axis_tdata[NUM_W+LET_W-1:NUM_W]),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.hit_count     (hit_count),
		.first_time    (first_time),
		.table_full    (table_full),
		.bucket_index  (bucket_index)
	);

	assign m_axis_tdata = {(OUT_DATA_W - HIT_CNT_W - BKT_W)'(0), bucket_index, hit_count};
	assign m_axis_tuser = {table_full, first_time};

`ifndef ASSERT_OFF
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_axis_tvalid)
		else $error("result committed but no output beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("pending result overwritten");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !s_axis_tready)
		else $error("new key taken during a lookup");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("first_time and table_full both set");
`endif

endmodule

`default_nettype wire

// File: src/poct_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module poct_ram #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 80
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/poct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module poct_ctrl
	import poct_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire poct_status_t status,
	output poct_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				// stop at the first matching way, or once every filled way is checked
				if (status.cmp_vld && status.match) begin
					state_d = ST_UPDATE;
				end else if (!status.issue_more && !status.cmp_vld) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.commit = status.out_free;
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: src/poct_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module poct_dp
	import poct_pkg::*;
#(
	parameter int WAYS       = 8,
	parameter int COUNT_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire poct_cmd_t        cmd,
	output poct_status_t          status,
	input  wire logic [NUM_W-1:0] plate_number,
	input  wire logic [LET_W-1:0] plate_letters,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic [HIT_CNT_W-1:0]  hit_count,
	output logic                  first_time,
	output logic                  table_full,
	output logic [BKT_W-1:0]      bucket_index
);

	localparam int ENTRIES = BUCKETS * WAYS;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FILL_W  = $clog2(WAYS + 1);
	localparam int ENT_W   = COUNT_BITS + LET_W + NUM_W;

	logic [NUM_W-1:0]      num_q;
	logic [LET_W-1:0]      let_q;
	logic [BKT_W-1:0]      bkt_q;
	logic [FILL_W-1:0]     fill_q [BUCKETS];
	logic [FILL_W-1:0]     cur_fill;
	logic [FILL_W-1:0]     w_q;
	logic                  cmp_vld_s1;
	logic [WAY_W-1:0]      cmp_way_s1;
	logic                  hit_q;
	logic [WAY_W-1:0]      hit_way_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [COUNT_BITS-1:0] rd_cnt_inc;
	logic [LET_W-1:0]      rd_let;
	logic [NUM_W-1:0]      rd_num;
	logic                  match;
	logic                  issue_more;
	logic                  bucket_full;
	logic                  out_free;
	logic [ADDR_W-1:0]     base;
	logic                  ram_re;
	logic [ADDR_W-1:0]     ram_raddr;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [ENT_W-1:0]      ram_wdata;
	logic [ENT_W-1:0]      ram_rdata;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [HIT_CNT_W+COUNT_BITS-1:0] cnt_ext;

	assign cur_fill    = fill_q[bkt_q];
	assign issue_more  = (w_q < cur_fill);
	assign bucket_full = (cur_fill == FILL_W'(WAYS));
	assign base        = ADDR_W'(bkt_q) * ADDR_W'(WAYS);

	assign {rd_cnt, rd_let, rd_num} = ram_rdata;
	assign match      = (rd_num == num_q) && (rd_let == let_q);
	assign rd_cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);

	assign ram_re    = cmd.search && issue_more;
	assign ram_raddr = base + ADDR_W'(w_q[WAY_W-1:0]);

	assign new_cnt   = hit_q ? hit_cnt_q : COUNT_BITS'(1);
	assign ram_we    = cmd.commit && (hit_q || !bucket_full);
	assign ram_waddr = base + ADDR_W'(hit_q ? hit_way_q : cur_fill[WAY_W-1:0]);
	assign ram_wdata = {new_cnt, let_q, num_q};

	assign out_free = !out_valid || out_ready;
	assign cnt_ext  = {{HIT_CNT_W{1'b0}}, new_cnt};

	assign status.issue_more = issue_more;
	assign status.cmp_vld    = cmp_vld_s1;
	assign status.match      = match;
	assign status.out_free   = out_free;

	poct_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ENTRIES)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// key registers, the hit record and the result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= plate_number;
			let_q <= plate_letters;
			bkt_q <= bucket_of(plate_letters[15:8]);
		end
		if (ram_re) begin
			cmp_way_s1 <= w_q[WAY_W-1:0];
		end
		if (cmd.search && cmp_vld_s1 && match) begin
			hit_way_q <= cmp_way_s1;
			hit_cnt_q <= rd_cnt_inc;
		end
		if (cmd.commit) begin
			hit_count    <= (hit_q || !bucket_full) ? cnt_ext[HIT_CNT_W-1:0] : '0;
			first_time   <= !hit_q && !bucket_full;
			table_full   <= !hit_q && bucket_full;
			bucket_index <= bkt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			out_valid  <= 1'b0;
			for (int b = 0; b < BUCKETS; b++) begin
				fill_q[b] <= '0;
			end
		end else begin
			if (cmd.load) begin
				w_q        <= '0;
				cmp_vld_s1 <= 1'b0;
				hit_q      <= 1'b0;
			end else if (cmd.search) begin
				cmp_vld_s1 <= issue_more;
				if (issue_more) w_q <= w_q + FILL_W'(1);
				if (cmp_vld_s1 && match) hit_q <= 1'b1;
			end
			// ways fill from the bottom and never free, so a count per bucket marks validity
			if (cmd.commit && !hit_q && !bucket_full) begin
				fill_q[bkt_q] <= cur_fill + FILL_W'(1);
			end
			if (cmd.commit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: dv/tb_plate_occurrence_counting_table.sv
`timescale 1ns / 1ps

module tb_plate_occurrence_counting_table;
	import poct_pkg::*;

	localparam int WAYS       = 8;
	localparam int COUNT_BITS = 16;
	localparam int SLOTS      = BUCKETS * WAYS;
	localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
	localparam int POOL_KEYS  = 40;
	localparam int RANDOM_KEYS = 700;
	localparam int HAMMER_HITS = 72;

	typedef struct packed {
		logic [HIT_CNT_W-1:0] hit_count;
		logic                 first_time;
		logic                 table_full;
		logic [BKT_W-1:0]     bucket;
	} plate_result_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [LET_W-1:0] ltrs;
		plate_result_t    want;
	} plate_row_t;

	localparam int DIR_N = 28;
	// Fill bucket 0 with eight keys, then overflow it and hit its first key again; every edge letter of buckets 1..9 once.
	localparam plate_row_t DIR_ROWS [DIR_N] = '{
		'{10'd0,    24'h000000,             '{16'd1, 1'b1, 1'b0, 4'd0}},
		'{10'd1023, 24'hffffff,             '{16'd1, 1'b1, 1'b0, 4'd0}},
		'{10'd512,  {8'h71, CH_A, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd1}},
		'{10'd999,  {8'h71, CH_C, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd1}},
		'{10'd512,  {8'h71, CH_D, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd2}},
		'{10'd999,  {8'h71, CH_F, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd2}},
		'{10'd512,  {8'h71, CH_G, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd3}},
		'{10'd999,  {8'h71, CH_I, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd3}},
		'{10'd512,  {8'h71, CH_J, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd4}},
		'{10'd999,  {8'h71, CH_L, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd4}},
		'{10'd512,  {8'h71, CH_M, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd5}},
		'{10'd999,  {8'h71, CH_O, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd5}},
		'{10'd512,  {8'h71, CH_P, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd6}},
		'{10'd999,  {8'h71, CH_R, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd6}},
		'{10'd512,  {8'h71, CH_S, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd7}},
		'{10'd999,  {8'h71, CH_U, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd7}},
		'{10'd512,  {8'h71, CH_V, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd8}},
		'{10'd999,  {8'h71, CH_X, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd8}},
		'{10'd512,  {8'h71, CH_Y, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd9}},
		'{10'd999,  {8'h71, CH_Z, 8'h6b},   '{16'd1, 1'b1, 1'b0, 4'd9}},
		'{10'd5,    {8'h61, 8'h60, 8'h7a},  '{16'd1, 1'b1, 1'b0, 4'd0}},
		'{10'd5,    {8'h61, 8'h7b, 8'h7a},  '{16'd1, 1'b1, 1'b0, 4'd0}},
		'{10'd5,    {8'h61, 8'h41, 8'h7a},  '{16'd1, 1'b1, 1'b0, 4'd0}},
		'{10'd5,    {8'h61, 8'h5a, 8'h7a},  '{16'd1, 1'b1, 1'b0, 4'd0}},
		'{10'd5,    {8'h61, 8'h80, 8'h7a},  '{16'd1, 1'b1, 1'b0, 4'd0}},
		'{10'd5,    {8'h61, 8'h30, 8'h7a},  '{16'd1, 1'b1, 1'b0, 4'd0}},
		'{10'd6,    {8'h61, 8'h60, 8'h7a},  '{16'd0, 1'b0, 1'b1, 4'd0}},
		'{10'd0,    24'h000000,             '{16'd2, 1'b0, 1'b0, 4'd0}}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;  // plate_number[9:0], plate_letters[33:10]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;  // hit_count[15:0], bucket_index[19:16]
	logic [OUT_USER_W-1:0] m_axis_tuser;  // first_time[0], table_full[1]

	bit                    slot_used [SLOTS];
	logic [NUM_W-1:0]      slot_num  [SLOTS];
	logic [LET_W-1:0]      slot_ltrs [SLOTS];
	logic [COUNT_BITS-1:0] slot_cnt  [SLOTS];

	plate_result_t plate_results_due [$];
	int            mismatches = 0;
	bit            calm = 1'b0;

	plate_occurrence_counting_table #(
		.WAYS       (WAYS),
		.COUNT_BITS (COUNT_BITS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Look the key up in the mirrored table and apply the same update the block makes.
	function automatic plate_result_t count_plate(input logic [NUM_W-1:0] num,
		input logic [LET_W-1:0] ltrs);
		plate_result_t r;
		logic [7:0]    mid;
		int            base;
		int            free_way;
		int            w;
		bit            found;
		r = '0;
		mid = ltrs[15:8];
		if (mid >= CH_A && mid <= CH_Z) begin
			r.bucket = BKT_W'((mid - CH_A) / 3 + 1);
		end
		base = int'(r.bucket) * WAYS;
		free_way = -1;
		found = 1'b0;
		for (w = 0; w < WAYS; w++) begin
			if (slot_used[base + w]) begin
				if (!found && slot_num[base + w] == num && slot_ltrs[base + w] == ltrs) begin
					if (slot_cnt[base + w] != COUNT_TOP) slot_cnt[base + w]++;
					r.hit_count = HIT_CNT_W'(slot_cnt[base + w]);
					found = 1'b1;
				end
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		if (!found) begin
			if (free_way >= 0) begin
				slot_used[base + free_way] = 1'b1;
				slot_num[base + free_way]  = num;
				slot_ltrs[base + free_way] = ltrs;
				slot_cnt[base + free_way]  = COUNT_BITS'(1);
				r.hit_count  = HIT_CNT_W'(1);
				r.first_time = 1'b1;
			end else begin
				r.table_full = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic send_plate(input logic [NUM_W-1:0] num, input logic [LET_W-1:0] ltrs,
		input plate_result_t typed, input bit use_typed);
		plate_result_t predicted;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 17) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_W'({ltrs, num});
		do @(posedge clk); while (!s_axis_tready);
		predicted = count_plate(num, ltrs);
		plate_results_due.push_back(use_typed ? typed : predicted);
	endtask

	always @(negedge clk) begin
		if (arst_n) m_axis_tready <= calm || ($urandom_range(0, 99) >= 17);
	end

	always @(posedge clk) begin
		plate_result_t got;
		plate_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.hit_count  = m_axis_tdata[15:0];
			got.bucket     = m_axis_tdata[19:16];
			got.first_time = m_axis_tuser[0];
			got.table_full = m_axis_tuser[1];
			if (plate_results_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat count=%0d first=%0b full=%0b bucket=%0d",
					$time, got.hit_count, got.first_time, got.table_full, got.bucket);
			end else begin
				want = plate_results_due.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: expected count=%0d first=%0b full=%0b bucket=%0d, %s%0d %0b %0b %0d",
						$time, want.hit_count, want.first_time, want.table_full, want.bucket,
						"got ", got.hit_count, got.first_time, got.table_full, got.bucket);
				end
			end
		end
	end

	initial begin
		#60_000_000;
		$display("tb_plate_occurrence_counting_table NOT OK");
		$finish;
	end

	initial begin
		logic [NUM_W-1:0] pool_num  [POOL_KEYS];
		logic [LET_W-1:0] pool_ltrs [POOL_KEYS];
		logic [NUM_W-1:0] num;
		logic [LET_W-1:0] ltrs;
		int               i;
		int               k;
		int               pick;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < DIR_N; i++) begin
			send_plate(DIR_ROWS[i].num, DIR_ROWS[i].ltrs, DIR_ROWS[i].want, 1'b1);
		end

		// Hit one key (way 0 of its bucket) over and over to walk its count up.
		for (i = 0; i < HAMMER_HITS; i++) begin
			send_plate(DIR_ROWS[2].num, DIR_ROWS[2].ltrs, '0, 1'b0);
		end

		for (k = 0; k < POOL_KEYS; k++) begin
			pool_num[k]  = NUM_W'($urandom_range(0, 1023));
			pool_ltrs[k] = {8'($urandom), 8'($urandom_range(CH_A, CH_Z)), 8'($urandom)};
		end
		for (i = 0; i < RANDOM_KEYS; i++) begin
			calm = (i >= 300 && i < 450);
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				k    = $urandom_range(0, POOL_KEYS - 1);
				num  = pool_num[k];
				ltrs = pool_ltrs[k];
			end else if (pick < 90) begin
				num  = NUM_W'($urandom_range(0, 1023));
				ltrs = {8'($urandom), 8'($urandom_range(CH_A, CH_Z)), 8'($urandom)};
			end else begin
				num  = NUM_W'($urandom);
				ltrs = LET_W'($urandom);
			end
			send_plate(num, ltrs, '0, 1'b0);
		end
		calm = 1'b0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (plate_results_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_plate_occurrence_counting_table OK");
		end else begin
			$display("tb_plate_occurrence_counting_table NOT OK");
		end
		$finish;
	end

endmodule
